@@ rtl/core/c2p_pkg.sv @@
// Shared types, constants and the arctangent table for the circle-to-polygon block.
package c2p_pkg;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] radius;
		logic [6:0]         segment_count;
	} item_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               empty_res;
		logic               last;
	} res_t;

	// Per-vertex side data that rides along the pipeline.
	typedef struct packed {
		logic               empty;
		logic               last;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] rad;
	} meta_t;

	// Sequencer to CORDIC transfer.
	typedef struct packed {
		logic [15:0] angle;
		meta_t       meta;
	} vtx_t;

	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [32:0] GAIN_Q30 = 33'sd652032875;

	// round(2^32 * atan(2^-k) / (2*pi))
	function automatic logic [31:0] atan_turn(input int k);
		logic [31:0] t;
		case (k)
			0:       t = 32'd536870912;
			1:       t = 32'd316933406;
			2:       t = 32'd167458908;
			3:       t = 32'd85004756;
			4:       t = 32'd42667331;
			5:       t = 32'd21354465;
			6:       t = 32'd10679838;
			7:       t = 32'd5340245;
			8:       t = 32'd2670163;
			9:       t = 32'd1335087;
			10:      t = 32'd667544;
			11:      t = 32'd333772;
			12:      t = 32'd166886;
			13:      t = 32'd83443;
			14:      t = 32'd41722;
			15:      t = 32'd20861;
			16:      t = 32'd10430;
			17:      t = 32'd5215;
			18:      t = 32'd2608;
			19:      t = 32'd1304;
			20:      t = 32'd652;
			21:      t = 32'd326;
			22:      t = 32'd163;
			23:      t = 32'd81;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/core/circle_to_polygon_points.sv @@
// Top level: circle to polygon vertex generator.
//
// A transfer in (start high while busy is low) hands over a circle center, radius
// and vertex count N (clamped to MAX_SEGMENTS). The block then produces N
// vertices in order, center + radius * (cos, sin) of i/N turn, each shown for a
// single cycle with res_valid; the final one carries last. A radius that is not
// positive or N below 3 yields one result with empty_res and last set and a
// zero point. Results cannot be held off, so the receiver must take one in every
// cycle res_valid is high. Busy stays high through the angle-step division (one
// quotient bit per cycle) and then the vertex issue, so a new item is not taken
// until every vertex of the previous one has been issued; an empty item never
// raises busy. Each vertex passes through the CORDIC and placement stages after it
// is issued, and items come out in order, back to back with no overlap.
module circle_to_polygon_points #(
	parameter int MAX_SEGMENTS  = 64,
	parameter int CORDIC_STAGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  c2p_pkg::item_t item,
	output logic           busy,
	output logic           res_valid,
	output c2p_pkg::res_t  res
);

	logic               vtx_valid;
	c2p_pkg::vtx_t      vtx;
	logic               rot_valid;
	logic signed [32:0] rot_x, rot_y;
	logic [1:0]         rot_quad;
	c2p_pkg::meta_t     rot_meta;

	// divider + angle stepping
	c2p_angle_seq #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.vtx_valid (vtx_valid),
		.vtx       (vtx)
	);

	// cos/sin, one vertex per cycle
	c2p_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx_valid),
		.vtx       (vtx),
		.out_valid (rot_valid),
		.x         (rot_x),
		.y         (rot_y),
		.quad      (rot_quad),
		.meta      (rot_meta)
	);

	// scale, offset, saturate
	c2p_place u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.x         (rot_x),
		.y         (rot_y),
		.quad      (rot_quad),
		.meta      (rot_meta),
		.res_valid (res_valid),
		.res       (res)
	);

	// an empty result always closes its item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.empty_res |-> res.last)
		else $error("empty result without last");

	// an empty result carries no point
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.empty_res |-> (res.point_x == 32'sd0) && (res.point_y == 32'sd0))
		else $error("empty result with nonzero point");

	// busy only rises out of an accepted transfer
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transfer");

endmodule

@@ rtl/core/c2p_angle_seq.sv @@
// Angle sequencer: divides a turn by N, then steps out N vertex angles.
module c2p_angle_seq #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  c2p_pkg::item_t item,
	output logic           busy,
	output logic           vtx_valid,
	output c2p_pkg::vtx_t  vtx
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [6:0] NMAX    = 7'(MAX_SEGMENTS);
	localparam logic [4:0] DIV_LAST = 5'd16;

	logic [1:0]         state_q;
	logic [6:0]         n_q;
	logic signed [31:0] cx_q, cy_q, rad_q;
	logic [4:0]         cnt_q;
	logic [5:0]         rem_q;
	logic [15:0]        quo_q;
	logic [15:0]        angle_q;
	logic [5:0]         frac_q;
	logic [6:0]         idx_q;
	logic               vtx_valid_q;
	c2p_pkg::vtx_t      vtx_q;

	logic [6:0] n_in;
	logic       bad_in;
	logic [6:0] div_r;
	logic       div_ge;
	logic [6:0] frac_sum;
	logic       frac_ge;

	assign n_in     = (item.segment_count > NMAX) ? NMAX : item.segment_count;
	assign bad_in   = (item.radius <= 32'sd0) || (n_in < 7'd3);
	// dividend is 2^16: only its top bit is set
	assign div_r    = {rem_q, (cnt_q == 5'd0)};
	assign div_ge   = (div_r >= n_q);
	assign frac_sum = {1'b0, frac_q} + {1'b0, rem_q};
	assign frac_ge  = (frac_sum >= n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vtx_valid_q <= 1'b0;
		end else begin
			vtx_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (bad_in) begin
							vtx_valid_q <= 1'b1;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					vtx_valid_q <= 1'b1;
					if (idx_q == n_q - 7'd1) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q   <= n_in;
				cx_q  <= item.center_x;
				cy_q  <= item.center_y;
				rad_q <= item.radius;
				cnt_q <= 5'd0;
				rem_q <= 6'd0;
				quo_q <= 16'd0;
				vtx_q.angle      <= 16'd0;
				vtx_q.meta.empty <= 1'b1;
				vtx_q.meta.last  <= 1'b1;
				vtx_q.meta.cx    <= 32'sd0;
				vtx_q.meta.cy    <= 32'sd0;
				vtx_q.meta.rad   <= 32'sd0;
			end
			ST_DIV: begin
				cnt_q   <= cnt_q + 5'd1;
				rem_q   <= div_ge ? 6'(div_r - n_q) : div_r[5:0];
				quo_q   <= {quo_q[14:0], div_ge};
				angle_q <= 16'd0;
				frac_q  <= 6'd0;
				idx_q   <= 7'd0;
			end
			ST_EMIT: begin
				vtx_q.angle      <= angle_q;
				vtx_q.meta.empty <= 1'b0;
				vtx_q.meta.last  <= (idx_q == n_q - 7'd1);
				vtx_q.meta.cx    <= cx_q;
				vtx_q.meta.cy    <= cy_q;
				vtx_q.meta.rad   <= rad_q;
				idx_q  <= idx_q + 7'd1;
				frac_q <= frac_ge ? 6'(frac_sum - n_q) : frac_sum[5:0];
				angle_q <= angle_q + quo_q + {15'd0, frac_ge};
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign vtx_valid = vtx_valid_q;
	assign vtx       = vtx_q;

endmodule

@@ rtl/core/c2p_cordic.sv @@
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
module c2p_cordic #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  c2p_pkg::vtx_t       vtx,
	output logic                out_valid,
	output logic signed [32:0]  x,
	output logic signed [32:0]  y,
	output logic [1:0]          quad,
	output c2p_pkg::meta_t      meta
);

	logic                v_s    [0:CORDIC_STAGES];
	logic signed [32:0]  x_s    [0:CORDIC_STAGES];
	logic signed [32:0]  y_s    [0:CORDIC_STAGES];
	logic signed [32:0]  z_s    [0:CORDIC_STAGES];
	logic [1:0]          quad_s [0:CORDIC_STAGES];
	c2p_pkg::meta_t      meta_s [0:CORDIC_STAGES];

	// entry stage: split quadrant, residual to 2^-32 turn units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else         v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= c2p_pkg::GAIN_Q30;
		y_s[0]    <= 33'sd0;
		z_s[0]    <= $signed({3'b000, vtx.angle[13:0], 16'h0000});
		quad_s[0] <= vtx.angle[15:14];
		meta_s[0] <= vtx.meta;
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
		localparam logic signed [32:0] ATAN_K = $signed({1'b0, c2p_pkg::atan_turn(k)});
		logic signed [32:0] dx, dy;
		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else         v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (!z_s[k][32]) begin
				x_s[k+1] <= x_s[k] - dx;
				y_s[k+1] <= y_s[k] + dy;
				z_s[k+1] <= z_s[k] - ATAN_K;
			end else begin
				x_s[k+1] <= x_s[k] + dx;
				y_s[k+1] <= y_s[k] - dy;
				z_s[k+1] <= z_s[k] + ATAN_K;
			end
			quad_s[k+1] <= quad_s[k];
			meta_s[k+1] <= meta_s[k];
		end
	end

	assign out_valid = v_s[CORDIC_STAGES];
	assign x         = x_s[CORDIC_STAGES];
	assign y         = y_s[CORDIC_STAGES];
	assign quad      = quad_s[CORDIC_STAGES];
	assign meta      = meta_s[CORDIC_STAGES];

endmodule

@@ rtl/core/c2p_place.sv @@
// Quadrant fold, radius scaling, rounding, center offset and saturation.
module c2p_place (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [32:0] x,
	input  logic signed [32:0] y,
	input  logic [1:0]         quad,
	input  c2p_pkg::meta_t     meta,
	output logic               res_valid,
	output c2p_pkg::res_t      res
);

	localparam logic signed [63:0] HALF   = 64'sd536870912;
	localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
	localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

	logic signed [32:0] c_w, s_w;
	logic               v_s1, v_s2, v_s3;
	logic signed [31:0] c_s1, s_s1;
	c2p_pkg::meta_t     meta_s1, meta_s2;
	logic signed [63:0] px_s2, py_s2;
	c2p_pkg::res_t      res_s3;

	logic signed [63:0] rx, ry;
	logic signed [34:0] vx, vy;

	always_comb begin
		case (quad)
			2'd0:    begin c_w = x;  s_w = y;  end
			2'd1:    begin c_w = -y; s_w = x;  end
			2'd2:    begin c_w = -x; s_w = -y; end
			default: begin c_w = y;  s_w = -x; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: fold (|c|,|s| stay under 2^31)
	always_ff @(posedge clk) begin
		c_s1    <= c_w[31:0];
		s_s1    <= s_w[31:0];
		meta_s1 <= meta;
	end

	// stage 2: radius products
	always_ff @(posedge clk) begin
		px_s2   <= 64'(meta_s1.rad) * 64'(c_s1);
		py_s2   <= 64'(meta_s1.rad) * 64'(s_s1);
		meta_s2 <= meta_s1;
	end

	// stage 3: round half up, offset, saturate (scaled product keeps its sign)
	assign rx = px_s2 + HALF;
	assign ry = py_s2 + HALF;
	assign vx = 35'(meta_s2.cx) + 35'($signed(rx[63:30]));
	assign vy = 35'(meta_s2.cy) + 35'($signed(ry[63:30]));

	always_ff @(posedge clk) begin
		res_s3.empty_res <= meta_s2.empty;
		res_s3.last      <= meta_s2.last;
		if (meta_s2.empty) begin
			res_s3.point_x <= 32'sd0;
			res_s3.point_y <= 32'sd0;
		end else begin
			res_s3.point_x <= (vx > SAT_HI) ? 32'sh7FFFFFFF :
			                  (vx < SAT_LO) ? 32'sh80000000 : vx[31:0];
			res_s3.point_y <= (vy > SAT_HI) ? 32'sh7FFFFFFF :
			                  (vy < SAT_LO) ? 32'sh80000000 : vy[31:0];
		end
	end

	assign res_valid = v_s3;
	assign res       = res_s3;

endmodule
